### rtl/bpfa_pkg.sv
// shared types, constants and helpers of the bitmap page frame allocator
package bpfa_pkg;

  localparam int unsigned FRAMES_DEF = 4096;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned FRAME_W    = 12;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned LIMIT_W    = 13;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned BIT_W      = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 13'd4096;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_RESERVE = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOMEM = 2'd1,
    ST_RANGE = 2'd2,
    ST_SAME  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WORK,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic scan_step;
    logic apply;
    logic emit;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic work_done;
  } ctl_sts_t;

  // position of the lowest clear bit of a bitmap word
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

### rtl/bpfa_in_if.sv
// request channel: opcode and frame number with valid/ready
interface bpfa_in_if;
  logic                             valid;
  logic                             ready;
  logic [bpfa_pkg::OP_W-1:0]        opcode;
  logic [bpfa_pkg::FRAME_W-1:0]     frame_number;

  modport source (output valid, output opcode, output frame_number, input ready);
  modport sink   (input valid, input opcode, input frame_number, output ready);
endinterface

### rtl/bpfa_out_if.sv
// result channel: status, granted frame and free count with valid/ready
interface bpfa_out_if;
  logic                             valid;
  logic                             ready;
  logic [bpfa_pkg::STATUS_W-1:0]    status;
  logic [bpfa_pkg::FRAME_W-1:0]     granted_frame;
  logic [bpfa_pkg::COUNT_W-1:0]     free_count_now;

  modport source (output valid, output status, output granted_frame,
                  output free_count_now, input ready);
  modport sink   (input valid, input status, input granted_frame,
                  input free_count_now, output ready);
endinterface

### rtl/bitmap_page_frame_allocator_unit.sv
// Bitmap page frame allocator, first fit, one used bit per frame in a 64-bit wide RAM.
// Free, release and reserve read only the addressed word; alloc scans one bitmap word per cycle
// from word 0 (WORDS = FRAMES/64, 64 by default) until it finds a clear bit or reaches the last.
// The result then goes through the result and output registers, waiting while the last result is
// untaken; no new request is taken before that. After reset every frame is used, the free count is
// zero and a sweep fills the bitmap with ones, with no request taken until it ends.
module bitmap_page_frame_allocator_unit #(
  parameter int unsigned FRAMES = bpfa_pkg::FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bpfa_pkg::LIMIT_W-1:0]  cfg_wdata,
  bpfa_in_if.sink                       in_ch,
  bpfa_out_if.source                    out_ch
);

  bpfa_pkg::ctl_cmd_t cmd;
  bpfa_pkg::ctl_sts_t sts;

  // sequencing and handshakes
  bpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // bitmap, counter and result datapath
  bpfa_datapath #(
    .FRAMES (FRAMES)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_opcode          (in_ch.opcode),
    .in_frame_number    (in_ch.frame_number),
    .out_status         (out_ch.status),
    .out_granted_frame  (out_ch.granted_frame),
    .out_free_count_now (out_ch.free_count_now)
  );

endmodule

### rtl/bpfa_ram.sv
// generic simple dual-port ram, one write port, one registered read port
module bpfa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

### rtl/bpfa_datapath.sv
// bitmap storage, scan addressing, bit update, free counter and result registers
module bpfa_datapath #(
  parameter int unsigned FRAMES = bpfa_pkg::FRAMES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bpfa_pkg::ctl_cmd_t               cmd,
  output bpfa_pkg::ctl_sts_t               sts,
  input  logic                             cfg_we,
  input  logic [bpfa_pkg::LIMIT_W-1:0]     cfg_wdata,
  input  logic [bpfa_pkg::OP_W-1:0]        in_opcode,
  input  logic [bpfa_pkg::FRAME_W-1:0]     in_frame_number,
  output logic [bpfa_pkg::STATUS_W-1:0]    out_status,
  output logic [bpfa_pkg::FRAME_W-1:0]     out_granted_frame,
  output logic [bpfa_pkg::COUNT_W-1:0]     out_free_count_now
);

  localparam int unsigned WORDS = (FRAMES + 63) / 64;
  localparam int unsigned AW    = WORDS > 1 ? $clog2(WORDS) : 1;
  localparam int unsigned FW    = AW + bpfa_pkg::BIT_W;
  localparam int unsigned CW    = (FW > bpfa_pkg::LIMIT_W ? FW : bpfa_pkg::LIMIT_W) + 1;
  localparam logic [AW-1:0] LAST_ADDR  = AW'(WORDS - 1);
  localparam logic [AW-1:0] FIRST_STEP = AW'(WORDS > 1 ? 1 : 0);
  localparam logic [CW-1:0] FRAMES_C   = CW'(FRAMES);

  logic [bpfa_pkg::LIMIT_W-1:0]  limit_r;
  logic [bpfa_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic [AW-1:0]                 scan_addr_r, scan_addr_nxt;
  logic [AW-1:0]                 chk_addr_r;
  bpfa_pkg::opcode_t             op_r;
  logic [bpfa_pkg::FRAME_W-1:0]  frame_r;
  bpfa_pkg::status_t             res_status_r, res_status;
  logic [bpfa_pkg::FRAME_W-1:0]  res_granted_r, res_granted;
  logic [bpfa_pkg::STATUS_W-1:0] out_status_r;
  logic [bpfa_pkg::FRAME_W-1:0]  out_granted_r;
  logic [bpfa_pkg::COUNT_W-1:0]  out_count_r;

  logic [AW-1:0]                 rd_addr, in_word;
  logic [bpfa_pkg::WORD_W-1:0]   word, upd_word, ram_wdata;
  logic [AW-1:0]                 ram_waddr;
  logic                          ram_we, upd_we;
  logic                          found, cur;
  logic [bpfa_pkg::BIT_W-1:0]    bitpos, bsel;
  logic [CW-1:0]                 lim, cand, frame_c, limit_c;

  // frame limit in force
  assign limit_c = CW'(limit_r);
  assign lim     = (limit_c < FRAMES_C) ? limit_c : FRAMES_C;

  // read address: word 0 for alloc or the addressed word on accept, then the scan pointer
  assign in_word = AW'(32'(in_frame_number) >> bpfa_pkg::BIT_W);
  always_comb begin
    if (cmd.load) begin
      rd_addr = (bpfa_pkg::opcode_t'(in_opcode) == bpfa_pkg::OP_ALLOC) ? '0 : in_word;
    end else begin
      rd_addr = scan_addr_r;
    end
  end

  // scan pointer doubles as the clear sweep counter
  always_comb begin
    scan_addr_nxt = scan_addr_r;
    if (cmd.clr_step) begin
      scan_addr_nxt = (scan_addr_r == LAST_ADDR) ? '0 : scan_addr_r + AW'(1);
    end else if (cmd.load) begin
      scan_addr_nxt = FIRST_STEP;
    end else if (cmd.scan_step && scan_addr_r != LAST_ADDR) begin
      scan_addr_nxt = scan_addr_r + AW'(1);
    end
  end

  // examine the word that came back and work out the update
  assign found   = (word != '1);
  assign bitpos  = bpfa_pkg::first_zero(word);
  assign cand    = CW'({chk_addr_r, bitpos});
  assign frame_c = CW'(frame_r);
  assign bsel    = frame_r[bpfa_pkg::BIT_W-1:0];
  assign cur     = word[bsel];

  always_comb begin
    res_status  = bpfa_pkg::ST_OK;
    res_granted = '0;
    upd_word    = word;
    upd_we      = 1'b0;
    count_nxt   = count_r;
    case (op_r)
      bpfa_pkg::OP_ALLOC: begin
        if (found && cand < lim) begin
          upd_word    = word | (64'd1 << bitpos);
          upd_we      = 1'b1;
          count_nxt   = count_r - 13'd1;
          res_granted = bpfa_pkg::FRAME_W'(cand);
        end else begin
          res_status = bpfa_pkg::ST_NOMEM;
        end
      end
      default: begin
        if (op_r == bpfa_pkg::OP_FREE && frame_r == '0) begin
          res_status = bpfa_pkg::ST_SAME;
        end else if (frame_c >= lim) begin
          res_status = bpfa_pkg::ST_RANGE;
        end else if (op_r == bpfa_pkg::OP_RESERVE) begin
          if (!cur) begin
            upd_word  = word | (64'd1 << bsel);
            upd_we    = 1'b1;
            count_nxt = count_r - 13'd1;
          end else begin
            res_status = bpfa_pkg::ST_SAME;
          end
        end else begin
          if (cur) begin
            upd_word  = word & ~(64'd1 << bsel);
            upd_we    = 1'b1;
            count_nxt = count_r + 13'd1;
          end else begin
            res_status = bpfa_pkg::ST_SAME;
          end
        end
      end
    endcase
  end

  // ram write: clear sweep fills with ones, apply writes the updated word
  always_comb begin
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = scan_addr_r;
      ram_wdata = '1;
    end else begin
      ram_we    = cmd.apply && upd_we;
      ram_waddr = chk_addr_r;
      ram_wdata = upd_word;
    end
  end

  bpfa_ram #(
    .WIDTH (bpfa_pkg::WORD_W),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (rd_addr),
    .rdata_r (word)
  );

  // status back to the controller
  assign sts.clr_last  = (scan_addr_r == LAST_ADDR);
  assign sts.work_done = (op_r != bpfa_pkg::OP_ALLOC) || found || (chk_addr_r == LAST_ADDR);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= bpfa_pkg::LIMIT_RST;
      count_r     <= '0;
      scan_addr_r <= '0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      if (cmd.apply) count_r <= count_nxt;
      scan_addr_r <= scan_addr_nxt;
    end
  end

  // request, address and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= bpfa_pkg::opcode_t'(in_opcode);
      frame_r <= in_frame_number;
    end
    if (cmd.load || cmd.scan_step) chk_addr_r <= rd_addr;
    if (cmd.apply) begin
      res_status_r  <= res_status;
      res_granted_r <= res_granted;
    end
    if (cmd.emit) begin
      out_status_r  <= res_status_r;
      out_granted_r <= res_granted_r;
      out_count_r   <= count_r;
    end
  end

  assign out_status         = out_status_r;
  assign out_granted_frame  = out_granted_r;
  assign out_free_count_now = out_count_r;

  // the free count moves by at most one frame per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r)) || (count_r == $past(count_r) + 13'd1) ||
                     (count_r == $past(count_r) - 13'd1))
    else $error("free count jumped by more than one");

endmodule

### rtl/bpfa_ctrl.sv
// sequencing state machine and result handshake of the frame allocator
module bpfa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output bpfa_pkg::ctl_cmd_t  cmd,
  input  bpfa_pkg::ctl_sts_t  sts
);

  bpfa_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  // state register and result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpfa_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      bpfa_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = bpfa_pkg::S_IDLE;
      end
      bpfa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = bpfa_pkg::S_WORK;
        end
      end
      bpfa_pkg::S_WORK: begin
        if (sts.work_done) begin
          cmd.apply = 1'b1;
          state_nxt = bpfa_pkg::S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      bpfa_pkg::S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = bpfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bpfa_pkg::S_CLEAR;
      end
    endcase
  end

  // result beat held until taken
  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  // an accepted beat always starts work on the next cycle
  a_accept_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == bpfa_pkg::S_WORK)
    else $error("accepted beat did not start work");

  // a pending result never gets overwritten by a new emit
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !cmd.emit)
    else $error("result overwritten before it was taken");

  // the clear sweep only runs right after reset
  a_no_reclear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != bpfa_pkg::S_CLEAR |=> state_r != bpfa_pkg::S_CLEAR)
    else $error("clear sweep restarted");

endmodule

### bench/testbench.sv
// self-checking bench for the bitmap page frame allocator: directed table, then random traffic
`timescale 1ns / 1ps

module testbench;

  localparam int FRAMES      = bpfa_pkg::FRAMES_DEF;
  localparam int FRAME_W     = bpfa_pkg::FRAME_W;
  localparam int COUNT_W     = bpfa_pkg::COUNT_W;
  localparam int LIMIT_W     = bpfa_pkg::LIMIT_W;
  localparam int PERIOD_NS   = 12;
  localparam int RESET_CYC   = 12;
  localparam int SWEEP_CYC   = FRAMES / 64 + 8;
  localparam int SETTLE_CYC  = 8;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 183;
  localparam int HOLD_BEAT   = 300;
  localparam int HOLD_CYC    = 400;
  // ~1850 beats, each budgeted for a full scan, the longest gap and the longest stall, then x5
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    bpfa_pkg::status_t  status;
    logic [FRAME_W-1:0] granted;
    logic [COUNT_W-1:0] free_now;
  } outcome_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [LIMIT_W-1:0] limit;
    bpfa_pkg::opcode_t  op;
    logic [FRAME_W-1:0] frame;
    logic               typed;
    outcome_t           want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  bpfa_in_if  in_ch ();
  bpfa_out_if out_ch ();

  // bitmap, free count and limit as the bench sees them
  logic [FRAMES-1:0]  frame_used;
  int                 free_tally;
  logic [LIMIT_W-1:0] limit_reg;

  outcome_t           outcomes_due [$];
  logic [FRAME_W-1:0] granted_frames [$];
  int                 mismatches = 0;
  int                 offered = 0;
  int                 cycles = 0;

  bitmap_page_frame_allocator_unit #(.FRAMES(FRAMES)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #(PERIOD_NS / 2) clk = ~clk;

  function automatic int active_limit();
    return (int'(limit_reg) < FRAMES) ? int'(limit_reg) : FRAMES;
  endfunction

  // outcome of one request, updating the bitmap and the count
  function automatic outcome_t bitmap_outcome(bpfa_pkg::opcode_t op, logic [FRAME_W-1:0] f);
    outcome_t res;
    int       lim;
    int       hit;
    lim         = active_limit();
    res.status  = bpfa_pkg::ST_OK;
    res.granted = '0;
    hit         = -1;
    if (op == bpfa_pkg::OP_ALLOC) begin
      // first fit over the whole map, granted only below the limit
      for (int i = 0; i < FRAMES && hit < 0; i++) begin
        if (!frame_used[i]) hit = i;
      end
      if (hit >= 0 && hit < lim) begin
        frame_used[hit] = 1'b1;
        free_tally--;
        res.granted = FRAME_W'(hit);
        granted_frames.push_back(res.granted);
        if (granted_frames.size() > 64) void'(granted_frames.pop_front());
      end else begin
        res.status = bpfa_pkg::ST_NOMEM;
      end
    end else if (op == bpfa_pkg::OP_FREE && f == '0) begin
      res.status = bpfa_pkg::ST_SAME;
    end else if (int'(f) >= lim) begin
      res.status = bpfa_pkg::ST_RANGE;
    end else if (op == bpfa_pkg::OP_RESERVE) begin
      if (frame_used[f]) begin
        res.status = bpfa_pkg::ST_SAME;
      end else begin
        frame_used[f] = 1'b1;
        free_tally--;
      end
    end else begin
      // free and release both clear a used bit
      if (!frame_used[f]) begin
        res.status = bpfa_pkg::ST_SAME;
      end else begin
        frame_used[f] = 1'b0;
        free_tally++;
      end
    end
    res.free_now = COUNT_W'(free_tally);
    return res;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic bpfa_pkg::opcode_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return bpfa_pkg::OP_ALLOC;
    if (r < 60) return bpfa_pkg::OP_FREE;
    if (r < 85) return bpfa_pkg::OP_RELEASE;
    return bpfa_pkg::OP_RESERVE;
  endfunction

  // low window, limit edge, recent grants, or anywhere
  function automatic logic [FRAME_W-1:0] pick_frame();
    int lim;
    int r;
    int hi;
    int v;
    lim = active_limit();
    r   = $urandom_range(0, 99);
    if (r < 40) begin
      hi = (lim < 128) ? lim : 128;
      v  = int'($urandom_range(0, hi));
    end else if (r < 60) begin
      v = lim - 2 + int'($urandom_range(0, 3));
    end else if (r < 80 && granted_frames.size() > 0) begin
      v = int'(granted_frames[$urandom_range(0, granted_frames.size() - 1)]);
    end else begin
      v = int'($urandom_range(0, FRAMES - 1));
    end
    if (v < 0) v = 0;
    if (v > FRAMES - 1) v = FRAMES - 1;
    return FRAME_W'(v);
  endfunction

  function automatic stim_row_t ask(bpfa_pkg::opcode_t op, logic [FRAME_W-1:0] f);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_REQ;
    row.op    = op;
    row.frame = f;
    return row;
  endfunction

  function automatic stim_row_t ask_chk(bpfa_pkg::opcode_t op, logic [FRAME_W-1:0] f,
                                        bpfa_pkg::status_t st, logic [FRAME_W-1:0] gr,
                                        logic [COUNT_W-1:0] cnt);
    stim_row_t row;
    row                = ask(op, f);
    row.typed          = 1'b1;
    row.want.status    = st;
    row.want.granted   = gr;
    row.want.free_now  = cnt;
    return row;
  endfunction

  function automatic stim_row_t set_limit(logic [LIMIT_W-1:0] value);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_CFG;
    row.limit = value;
    return row;
  endfunction

  // offer one request and queue its outcome once the beat is taken
  task automatic send_request(input bpfa_pkg::opcode_t op, input logic [FRAME_W-1:0] f,
                              input logic typed, input outcome_t want);
    outcome_t due;
    int       gap;
    gap = pick_gap(((offered / 150) % 4) == 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.frame_number <= f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    due = bitmap_outcome(op, f);
    outcomes_due.push_back(typed ? want : due);
    offered++;
  endtask

  // limit writes only once the block has drained
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    limit_reg = value;
    cfg_we    <= 1'b0;
  endtask

  task automatic check_result();
    outcome_t want;
    if (outcomes_due.size() == 0) begin
      $error("result beat with no request pending: status %0d frame %0d count %0d",
             out_ch.status, out_ch.granted_frame, out_ch.free_count_now);
      mismatches++;
    end else begin
      want = outcomes_due.pop_front();
      if (out_ch.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_ch.status);
        mismatches++;
      end
      if (out_ch.granted_frame !== want.granted) begin
        $error("granted_frame: expected %0d, got %0d", want.granted, out_ch.granted_frame);
        mismatches++;
      end
      if (out_ch.free_count_now !== want.free_now) begin
        $error("free_count_now: expected %0d, got %0d", want.free_now, out_ch.free_count_now);
        mismatches++;
      end
    end
  endtask

  // result side: check each beat, then maybe stall
  initial begin : result_sink
    int stall_left;
    int beats;
    stall_left = 0;
    beats      = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        check_result();
        beats++;
        // one long hold so the block backs up into the request side
        if (beats == HOLD_BEAT) stall_left = HOLD_CYC;
        else stall_left = pick_gap(((beats / 170) % 4) == 2);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    stim_row_t          directed [$];
    logic [LIMIT_W-1:0] phase_limit [PHASES];
    bpfa_pkg::opcode_t  op;
    logic [FRAME_W-1:0] f;

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= bpfa_pkg::OP_ALLOC;
    in_ch.frame_number <= '0;
    frame_used  = '1;
    free_tally  = 0;
    limit_reg   = bpfa_pkg::LIMIT_RST;

    // everything used after reset
    directed.push_back(ask_chk(bpfa_pkg::OP_ALLOC, 12'd4095, bpfa_pkg::ST_NOMEM, 12'd0, 13'd0));
    // null frame, then free of a used frame and a double free, then release of frame zero twice
    directed.push_back(ask_chk(bpfa_pkg::OP_FREE, 12'd0, bpfa_pkg::ST_SAME, 12'd0, 13'd0));
    directed.push_back(ask_chk(bpfa_pkg::OP_FREE, 12'd5, bpfa_pkg::ST_OK, 12'd0, 13'd1));
    directed.push_back(ask_chk(bpfa_pkg::OP_FREE, 12'd5, bpfa_pkg::ST_SAME, 12'd0, 13'd1));
    directed.push_back(ask_chk(bpfa_pkg::OP_RELEASE, 12'd0, bpfa_pkg::ST_OK, 12'd0, 13'd2));
    directed.push_back(ask_chk(bpfa_pkg::OP_RELEASE, 12'd0, bpfa_pkg::ST_SAME, 12'd0, 13'd2));
    // frame zero is granted like any other
    directed.push_back(ask_chk(bpfa_pkg::OP_ALLOC, 12'd0, bpfa_pkg::ST_OK, 12'd0, 13'd1));
    directed.push_back(ask_chk(bpfa_pkg::OP_RESERVE, 12'd5, bpfa_pkg::ST_OK, 12'd0, 13'd0));
    directed.push_back(ask_chk(bpfa_pkg::OP_RESERVE, 12'd5, bpfa_pkg::ST_SAME, 12'd0, 13'd0));
    // top frame
    directed.push_back(ask_chk(bpfa_pkg::OP_RELEASE, 12'd4095, bpfa_pkg::ST_OK, 12'd0, 13'd1));
    directed.push_back(ask_chk(bpfa_pkg::OP_ALLOC, 12'd0, bpfa_pkg::ST_OK, 12'd4095, 13'd0));
    directed.push_back(ask_chk(bpfa_pkg::OP_ALLOC, 12'd0, bpfa_pkg::ST_NOMEM, 12'd0, 13'd0));
    directed.push_back(ask_chk(bpfa_pkg::OP_RELEASE, 12'd64, bpfa_pkg::ST_OK, 12'd0, 13'd1));
    // limit dropped below a free frame: it stays counted but cannot be granted
    directed.push_back(set_limit(13'd64));
    directed.push_back(ask_chk(bpfa_pkg::OP_ALLOC, 12'd0, bpfa_pkg::ST_NOMEM, 12'd0, 13'd1));
    directed.push_back(ask_chk(bpfa_pkg::OP_RELEASE, 12'd64, bpfa_pkg::ST_RANGE, 12'd0, 13'd1));
    directed.push_back(ask_chk(bpfa_pkg::OP_RESERVE, 12'd4095, bpfa_pkg::ST_RANGE, 12'd0,
                               13'd1));
    directed.push_back(ask_chk(bpfa_pkg::OP_RELEASE, 12'd63, bpfa_pkg::ST_OK, 12'd0, 13'd2));
    // zero limit
    directed.push_back(set_limit(13'd0));
    directed.push_back(ask_chk(bpfa_pkg::OP_ALLOC, 12'd0, bpfa_pkg::ST_NOMEM, 12'd0, 13'd2));
    directed.push_back(ask_chk(bpfa_pkg::OP_FREE, 12'd0, bpfa_pkg::ST_SAME, 12'd0, 13'd2));
    directed.push_back(ask_chk(bpfa_pkg::OP_RESERVE, 12'd0, bpfa_pkg::ST_RANGE, 12'd0, 13'd2));
    // limit above the frame count clips to it
    directed.push_back(set_limit(13'd8191));
    directed.push_back(ask(bpfa_pkg::OP_ALLOC,   12'd0));
    directed.push_back(ask(bpfa_pkg::OP_ALLOC,   12'd0));
    directed.push_back(set_limit(13'd4096));
    directed.push_back(ask(bpfa_pkg::OP_RELEASE, 12'hAAA));
    directed.push_back(ask(bpfa_pkg::OP_RELEASE, 12'h555));

    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;
    // block clears its bitmap before taking requests
    repeat (SWEEP_CYC) @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        write_limit(directed[i].limit);
      end else begin
        send_request(directed[i].op, directed[i].frame, directed[i].typed, directed[i].want);
      end
    end

    // random traffic over several limits
    phase_limit    = '{13'd4096, 13'd1, 13'd65, 13'd8191, 13'd4095,
                       13'd1000, 13'd2, 13'd64, 13'd128, 13'd4096};
    phase_limit[6] = LIMIT_W'($urandom_range(2, FRAMES - 1));
    for (int p = 0; p < PHASES; p++) begin
      write_limit(phase_limit[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = pick_op();
        f  = pick_frame();
        send_request(op, f, 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
